// ===== rtl/core/sctsc_pkg.sv =====
package sctsc_pkg;

  localparam int SETS_DEF      = 64;
  localparam int WAYS_DEF      = 4;
  localparam int ADDR_BITS_DEF = 32;

  localparam int ADDR_W    = 32;
  localparam int FUNC_W    = 2;
  localparam int STATE_W   = 2;
  localparam int WAY_OUT_W = 2;
  localparam int PDATA_W   = 32;
  localparam int PADDR_W   = 4;
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam int OFFSET_MAX = 12;
  localparam int INDEX_MAX  = 6;

  localparam logic [FUNC_W-1:0] FUNC_LOAD        = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STORE       = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SNOOP_LOAD  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_SNOOP_STORE = 2'd3;

  localparam logic [STATE_W-1:0] ST_INV = 2'd0;
  localparam logic [STATE_W-1:0] ST_VAL = 2'd1;
  localparam logic [STATE_W-1:0] ST_SHR = 2'd2;
  localparam logic [STATE_W-1:0] ST_MOD = 2'd3;

  localparam logic [1:0] MODE_PLAIN     = 2'd0;
  localparam logic [1:0] MODE_VI        = 2'd1;
  localparam logic [1:0] MODE_MSI       = 2'd2;
  localparam logic [1:0] MODE_MSI_ALIAS = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_PROTOCOL = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_INDEX    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_WAYS     = 2'd3;

  localparam logic [1:0] PROTOCOL_RST = 2'd0;
  localparam logic [3:0] OFFSET_RST   = 4'd4;
  localparam logic [2:0] INDEX_RST    = 3'd6;
  localparam logic [2:0] WAYS_RST     = 3'd4;

  typedef struct packed {
    logic [1:0] protocol_mode;
    logic [3:0] offset_bits;
    logic [2:0] index_bits;
    logic [2:0] ways_used;
  } cfg_t;

  typedef struct packed {
    logic                 hit;
    logic                 writeback;
    logic                 upgrade_miss;
    logic [WAY_OUT_W-1:0] way;
    logic [STATE_W-1:0]   new_state;
  } rsp_t;

endpackage

// ===== rtl/core/sctsc_if.sv =====
interface sctsc_req_if import sctsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output func, output address, input ready);
  modport sink (input valid, input func, input address, output ready);
endinterface

interface sctsc_rsp_if import sctsc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic                 writeback;
  logic                 upgrade_miss;
  logic [WAY_OUT_W-1:0] way;
  logic [STATE_W-1:0]   new_state;

  modport source (output valid, output hit, output writeback, output upgrade_miss,
                  output way, output new_state, input ready);
  modport sink (input valid, input hit, input writeback, input upgrade_miss,
                input way, input new_state, output ready);
endinterface

// ===== rtl/core/sctsc_cfg.sv =====
module sctsc_cfg import sctsc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t                 cfg_q, cfg_d;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_PROTOCOL: cfg_d.protocol_mode = pwdata[1:0];
        REG_OFFSET:   cfg_d.offset_bits   = pwdata[3:0];
        REG_INDEX:    cfg_d.index_bits    = pwdata[2:0];
        REG_WAYS:     cfg_d.ways_used     = pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PROTOCOL: prdata = PDATA_W'(cfg_q.protocol_mode);
      REG_OFFSET:   prdata = PDATA_W'(cfg_q.offset_bits);
      REG_INDEX:    prdata = PDATA_W'(cfg_q.index_bits);
      REG_WAYS:     prdata = PDATA_W'(cfg_q.ways_used);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{protocol_mode: PROTOCOL_RST, offset_bits: OFFSET_RST,
                 index_bits: INDEX_RST, ways_used: WAYS_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/core/sctsc_tag_mem.sv =====
module sctsc_tag_mem import sctsc_pkg::*; #(
  parameter int  DEPTH = SETS_DEF,
  parameter int  ROW_W = 8,
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [IW-1:0]    rd_addr_i,
  output logic [ROW_W-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [IW-1:0]    wr_addr_i,
  input  logic [ROW_W-1:0] wr_data_i,
  output logic             clr_busy_o
);

  logic [ROW_W-1:0] mem [DEPTH];
  logic [ROW_W-1:0] rd_data_q;
  logic             clr_busy_q, clr_busy_d;
  logic [IW-1:0]    clr_idx_q, clr_idx_d;
  logic             we;
  logic [IW-1:0]    waddr;
  logic [ROW_W-1:0] wdata;

  assign we         = clr_busy_q | wr_en_i;
  assign waddr      = clr_busy_q ? clr_idx_q : wr_addr_i;
  assign wdata      = clr_busy_q ? '0 : wr_data_i;
  assign rd_data_o  = rd_data_q;
  assign clr_busy_o = clr_busy_q;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_idx_d  = clr_idx_q;
    if (clr_busy_q) begin
      if (clr_idx_q == IW'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_idx_d = clr_idx_q + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_idx_q  <= clr_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

`ifndef SYNTHESIS
  a_no_access_during_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !wr_en_i && !rd_en_i)
    else $error("tag memory accessed during clearing pass");

  a_clear_runs_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_busy_q |=> !clr_busy_q)
    else $error("clearing pass restarted");
`endif

endmodule

// ===== rtl/core/sctsc_xform.sv =====
module sctsc_xform import sctsc_pkg::*; #(
  parameter int  WAYS  = WAYS_DEF,
  parameter int  TAG_W = ADDR_BITS_DEF,
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1,
  localparam int NW_W  = $clog2(WAYS + 1)
) (
  input  cfg_t                           cfg_i,
  input  logic [FUNC_W-1:0]              func_i,
  input  logic [TAG_W-1:0]               tag_i,
  input  logic [WAYS-1:0][TAG_W-1:0]     tags_i,
  input  logic [WAYS-1:0][STATE_W-1:0]   states_i,
  input  logic [WAYS-1:0]                dirty_i,
  input  logic [WW-1:0]                  victim_i,
  output logic                           wr_en_o,
  output logic [WAYS-1:0][TAG_W-1:0]     tags_o,
  output logic [WAYS-1:0][STATE_W-1:0]   states_o,
  output logic [WAYS-1:0]                dirty_o,
  output logic [WW-1:0]                  victim_o,
  output rsp_t                           rsp_o
);

  logic [NW_W-1:0]    nw;
  logic [WAYS-1:0]    match;
  logic               found;
  logic [WW-1:0]      hw;
  logic [WW-1:0]      vw;
  logic [WW-1:0]      sel;
  logic [STATE_W-1:0] st;
  logic [STATE_W-1:0] newst;
  logic               msi;
  logic               vi;
  logic               snoop;
  logic               store;
  logic               adv;

  assign msi   = (cfg_i.protocol_mode == MODE_MSI) || (cfg_i.protocol_mode == MODE_MSI_ALIAS);
  assign vi    = (cfg_i.protocol_mode == MODE_VI);
  assign snoop = (func_i == FUNC_SNOOP_LOAD) || (func_i == FUNC_SNOOP_STORE);
  assign store = (func_i == FUNC_STORE);

  always_comb begin
    if (cfg_i.ways_used == 3'd0) begin
      nw = NW_W'(1);
    end else if (32'(cfg_i.ways_used) > WAYS) begin
      nw = NW_W'(WAYS);
    end else begin
      nw = NW_W'(cfg_i.ways_used);
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = (NW_W'(w) < nw) && (states_i[w] != ST_INV) && (tags_i[w] == tag_i);
    end
    found = |match;
    hw    = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hw = WW'(w);
      end
    end
    vw = (NW_W'(victim_i) >= nw) ? '0 : victim_i;
  end

  always_comb begin
    tags_o   = tags_i;
    states_o = states_i;
    dirty_o  = dirty_i;
    victim_o = victim_i;
    wr_en_o  = 1'b0;
    rsp_o    = '0;
    adv      = 1'b0;
    sel      = found ? hw : vw;
    st       = states_i[sel];
    newst    = ST_INV;

    if (snoop) begin
      if (found) begin
        wr_en_o   = 1'b1;
        rsp_o.hit = 1'b1;
        if (msi) begin
          newst           = (func_i == FUNC_SNOOP_LOAD) ? ST_SHR : ST_INV;
          rsp_o.writeback = (st == ST_MOD);
        end else if (vi) begin
          newst           = ST_INV;
          rsp_o.writeback = dirty_i[sel];
        end else begin
          newst = ST_VAL;
        end
        states_o[sel] = newst;
      end
    end else if (found) begin
      wr_en_o = 1'b1;
      if (msi && store && (st != ST_MOD)) begin
        rsp_o.upgrade_miss = 1'b1;
        newst              = ST_MOD;
      end else begin
        rsp_o.hit = 1'b1;
        if (!msi) begin
          newst = ST_VAL;
        end else begin
          newst = (store || (st == ST_MOD)) ? ST_MOD : ST_SHR;
        end
      end
      states_o[sel] = newst;
      if (store) begin
        dirty_o[sel] = 1'b1;
        adv          = 1'b1;
      end
    end else begin
      wr_en_o         = 1'b1;
      rsp_o.writeback = msi ? (st == ST_MOD) : ((st != ST_INV) && dirty_i[sel]);
      newst           = msi ? (store ? ST_MOD : ST_SHR) : ST_VAL;
      tags_o[sel]     = tag_i;
      states_o[sel]   = newst;
      dirty_o[sel]    = store;
      adv             = 1'b1;
    end

    if (adv && (nw > NW_W'(1))) begin
      victim_o = ((NW_W'(sel) + NW_W'(1)) < nw) ? (sel + WW'(1)) : '0;
    end

    if (!snoop || found) begin
      rsp_o.way       = WAY_OUT_W'(sel);
      rsp_o.new_state = newst;
    end
  end

endmodule

// ===== rtl/core/snooping_cache_tag_state_controller.sv =====
// Channel  Direction  Handshake        Contents
// req_i    in         valid / ready    func, address
// rsp_o    out        valid / ready    hit, writeback, upgrade_miss, way, new_state
// APB      in         psel / penable   configuration registers, pready tied high
//
// For an access, the set's row is read from the tag memory in the accept cycle and
// the updated row is written back from S_LOOK once the output register is free.
// After reset the tag memory is cleared one set per cycle, and
// req_i.ready stays low until that pass is done.
// A result waiting on rsp_o does not stop the next access from being accepted;
// only the write-back cycle waits while the output register is still full.
module snooping_cache_tag_state_controller import sctsc_pkg::*; #(
  parameter int SETS      = SETS_DEF,
  parameter int WAYS      = WAYS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  sctsc_req_if.sink          req_i,
  sctsc_rsp_if.source        rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int AW       = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int SW       = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WW       = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W    = WAYS * (AW + STATE_W + 1) + WW;
  localparam int IDX_SPAN = 1 << INDEX_MAX;
  localparam int SH_W     = $clog2(OFFSET_MAX + INDEX_MAX + 1);
  localparam logic [ADDR_W-1:0] AMASK = {ADDR_W{1'b1}} >> (ADDR_W - AW);

  typedef enum logic {S_IDLE, S_LOOK} state_e;

  cfg_t cfg;

  logic [SW-1:0]          set_lut [IDX_SPAN];
  logic [ADDR_W-1:0]      addr_m;
  logic [3:0]             ob;
  logic [2:0]             ib;
  logic [ADDR_W-1:0]      shifted;
  logic [ADDR_W-1:0]      tag_shift;
  logic [INDEX_MAX-1:0]   idx_mask;
  logic [INDEX_MAX-1:0]   set_raw;
  logic [SW-1:0]          set_d, set_q;
  logic [AW-1:0]          tag_d, tag_q;
  logic [FUNC_W-1:0]      func_q;

  logic                   accept;
  logic                   upd_go;
  logic                   clr_busy;

  logic [ROW_W-1:0]                rd_row, wr_row;
  logic [WAYS-1:0][AW-1:0]         rd_tags, wr_tags;
  logic [WAYS-1:0][STATE_W-1:0]    rd_states, wr_states;
  logic [WAYS-1:0]                 rd_dirty, wr_dirty;
  logic [WW-1:0]                   rd_victim, wr_victim;
  logic                            xf_wr_en;
  rsp_t                            xf_rsp;

  state_e state_q, state_d;
  rsp_t   rsp_q, rsp_d;
  logic   rsp_valid_q, rsp_valid_d;

  sctsc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  for (genvar i = 0; i < IDX_SPAN; i++) begin : g_set_lut
    assign set_lut[i] = SW'(i % SETS);
  end

  always_comb begin
    addr_m    = req_i.address & AMASK;
    ob        = (cfg.offset_bits > 4'(OFFSET_MAX)) ? 4'(OFFSET_MAX) : cfg.offset_bits;
    ib        = (cfg.index_bits > 3'(INDEX_MAX)) ? 3'(INDEX_MAX) : cfg.index_bits;
    shifted   = addr_m >> ob;
    idx_mask  = ~({INDEX_MAX{1'b1}} << ib);
    set_raw   = shifted[INDEX_MAX-1:0] & idx_mask;
    set_d     = set_lut[set_raw];
    tag_shift = addr_m >> (SH_W'(ob) + SH_W'(ib));
    tag_d     = tag_shift[AW-1:0];
  end

  assign req_i.ready = (state_q == S_IDLE) && !clr_busy;
  assign accept      = req_i.valid && req_i.ready;
  assign upd_go      = (state_q == S_LOOK) && (!rsp_valid_q || rsp_o.ready);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= req_i.func;
      tag_q  <= tag_d;
      set_q  <= set_d;
    end
  end

  sctsc_tag_mem #(
    .DEPTH (SETS),
    .ROW_W (ROW_W)
  ) u_tag_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_addr_i  (set_d),
    .rd_data_o  (rd_row),
    .wr_en_i    (upd_go && xf_wr_en),
    .wr_addr_i  (set_q),
    .wr_data_i  (wr_row),
    .clr_busy_o (clr_busy)
  );

  assign {rd_victim, rd_dirty, rd_states, rd_tags} = rd_row;
  assign wr_row = {wr_victim, wr_dirty, wr_states, wr_tags};

  sctsc_xform #(
    .WAYS  (WAYS),
    .TAG_W (AW)
  ) u_xform (
    .cfg_i    (cfg),
    .func_i   (func_q),
    .tag_i    (tag_q),
    .tags_i   (rd_tags),
    .states_i (rd_states),
    .dirty_i  (rd_dirty),
    .victim_i (rd_victim),
    .wr_en_o  (xf_wr_en),
    .tags_o   (wr_tags),
    .states_o (wr_states),
    .dirty_o  (wr_dirty),
    .victim_o (wr_victim),
    .rsp_o    (xf_rsp)
  );

  always_comb begin
    state_d     = state_q;
    rsp_valid_d = rsp_valid_q;
    rsp_d       = rsp_q;
    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (upd_go) begin
          state_d     = S_IDLE;
          rsp_valid_d = 1'b1;
          rsp_d       = xf_rsp;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      rsp_q       <= rsp_d;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.hit          = rsp_q.hit;
  assign rsp_o.writeback    = rsp_q.writeback;
  assign rsp_o.upgrade_miss = rsp_q.upgrade_miss;
  assign rsp_o.way          = rsp_q.way;
  assign rsp_o.new_state    = rsp_q.new_state;

`ifndef SYNTHESIS
  a_accept_starts_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_LOOK)
    else $error("accepted transaction did not enter lookup");

  a_update_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_go |=> rsp_valid_q && state_q == S_IDLE)
    else $error("row update did not produce a result");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import sctsc_pkg::*;

  localparam int unsigned LINES       = SETS_DEF * WAYS_DEF;
  localparam int unsigned CYCLE_LIMIT = 300000;

  class tag_state_scoreboard;
    logic [ADDR_W-1:0]    line_tag   [LINES];
    logic [STATE_W-1:0]   line_state [LINES];
    bit                   line_dirty [LINES];
    logic [WAY_OUT_W-1:0] victim_ptr [SETS_DEF];

    logic [1:0] mode_q;
    logic [3:0] offset_q;
    logic [2:0] index_q;
    logic [2:0] ways_q;

    rsp_t        expected_rsps[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned hits;
    int unsigned writebacks;
    int unsigned upgrades;
    int unsigned snoop_misses;

    function new();
      for (int i = 0; i < LINES; i++) begin
        line_tag[i]   = '0;
        line_state[i] = ST_INV;
        line_dirty[i] = 1'b0;
      end
      for (int s = 0; s < SETS_DEF; s++) begin
        victim_ptr[s] = '0;
      end
      mode_q   = PROTOCOL_RST;
      offset_q = OFFSET_RST;
      index_q  = INDEX_RST;
      ways_q   = WAYS_RST;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] val);
      case (idx)
        REG_PROTOCOL: mode_q   = val[1:0];
        REG_OFFSET:   offset_q = val[3:0];
        REG_INDEX:    index_q  = val[2:0];
        REG_WAYS:     ways_q   = val[2:0];
        default: ;
      endcase
    endfunction

    function void bump_victim(int unsigned set, int unsigned w, int unsigned n);
      if (n > 1) begin
        victim_ptr[set] = WAY_OUT_W'((w + 1 < n) ? w + 1 : 0);
      end
    endfunction

    function void note_access(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] a);
      logic [1:0]         md;
      int unsigned        o;
      int unsigned        ix;
      int unsigned        n;
      int unsigned        set;
      int unsigned        base;
      int unsigned        hw;
      int unsigned        v;
      logic [ADDR_W-1:0]  tag;
      bit                 found;
      bit                 store;
      logic [STATE_W-1:0] cur;
      logic [STATE_W-1:0] nst;
      rsp_t               r;

      md    = (mode_q == MODE_MSI_ALIAS) ? MODE_MSI : mode_q;
      o     = (32'(offset_q) > OFFSET_MAX) ? OFFSET_MAX : 32'(offset_q);
      ix    = (32'(index_q) > INDEX_MAX) ? INDEX_MAX : 32'(index_q);
      n     = (ways_q == 3'd0) ? 1 : ((32'(ways_q) > WAYS_DEF) ? WAYS_DEF : 32'(ways_q));
      set   = ((a >> o) & ((32'd1 << ix) - 32'd1)) % SETS_DEF;
      tag   = a >> (o + ix);
      base  = set * WAYS_DEF;
      store = (f == FUNC_STORE);
      found = 1'b0;
      hw    = 0;
      r     = '0;

      for (int unsigned w = 0; w < n; w++) begin
        if (!found && line_state[base + w] != ST_INV && line_tag[base + w] == tag) begin
          found = 1'b1;
          hw    = w;
        end
      end

      if (f == FUNC_SNOOP_LOAD || f == FUNC_SNOOP_STORE) begin
        if (found) begin
          cur   = line_state[base + hw];
          r.hit = 1'b1;
          case (md)
            MODE_PLAIN: nst = ST_VAL;
            MODE_VI: begin
              nst         = ST_INV;
              r.writeback = line_dirty[base + hw];
            end
            default: begin
              nst         = (f == FUNC_SNOOP_LOAD) ? ST_SHR : ST_INV;
              r.writeback = (cur == ST_MOD);
            end
          endcase
          line_state[base + hw] = nst;
          r.way       = WAY_OUT_W'(hw);
          r.new_state = nst;
        end else begin
          snoop_misses++;
        end
      end else if (found) begin
        cur = line_state[base + hw];
        if (md == MODE_MSI && store && cur != ST_MOD) begin
          r.upgrade_miss = 1'b1;
          nst            = ST_MOD;
        end else begin
          r.hit = 1'b1;
          if (md != MODE_MSI) begin
            nst = ST_VAL;
          end else begin
            nst = (store || cur == ST_MOD) ? ST_MOD : ST_SHR;
          end
        end
        line_state[base + hw] = nst;
        if (store) begin
          line_dirty[base + hw] = 1'b1;
          bump_victim(set, hw, n);
        end
        r.way       = WAY_OUT_W'(hw);
        r.new_state = nst;
      end else begin
        v = 32'(victim_ptr[set]);
        if (v >= n) begin
          v = 0;
        end
        cur = line_state[base + v];
        if (md == MODE_MSI) begin
          r.writeback = (cur == ST_MOD);
        end else begin
          r.writeback = (cur != ST_INV) && line_dirty[base + v];
        end
        nst                  = (md == MODE_MSI) ? (store ? ST_MOD : ST_SHR) : ST_VAL;
        line_tag[base + v]   = tag;
        line_state[base + v] = nst;
        line_dirty[base + v] = store;
        bump_victim(set, v, n);
        r.way       = WAY_OUT_W'(v);
        r.new_state = nst;
      end

      hits       += 32'(r.hit);
      writebacks += 32'(r.writeback);
      upgrades   += 32'(r.upgrade_miss);
      expected_rsps.push_back(r);
    endfunction

    function string show(rsp_t r);
      return $sformatf("hit=%0b wb=%0b upg=%0b way=%0d state=%0d",
                       r.hit, r.writeback, r.upgrade_miss, r.way, r.new_state);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) begin
        $display("ERROR at %0t: %s", $realtime, msg);
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      checked++;
      if (expected_rsps.size() == 0) begin
        report({"result with no access pending: ", show(got)});
        return;
      end
      want = expected_rsps.pop_front();
      if (got.hit !== want.hit || got.writeback !== want.writeback ||
          got.upgrade_miss !== want.upgrade_miss || got.way !== want.way ||
          got.new_state !== want.new_state) begin
        report({"result ", $sformatf("%0d", checked), " expected ", show(want),
                " got ", show(got)});
      end
    endfunction

    function int unsigned pending();
      return expected_rsps.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  sctsc_req_if req ();
  sctsc_rsp_if rsp ();

  snooping_cache_tag_state_controller u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rsp_o   (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tag_state_scoreboard sb = new();

  int unsigned       cycle_count;
  int unsigned       settings_done;
  bit                req_steady;
  bit                long_hold_done;
  int unsigned       stall_left;
  logic [ADDR_W-1:0] pool_tags [4];
  logic [ADDR_W-1:0] pool_sets [4];

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
    end
    $display("snooping_cache_tag_state_controller: mismatch");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      return FUNC_LOAD;
    end
    if (r < 7) begin
      return FUNC_STORE;
    end
    if (r < 9) begin
      return FUNC_SNOOP_LOAD;
    end
    return FUNC_SNOOP_STORE;
  endfunction

  // Most addresses come from a few tags and sets so that lines are hit,
  // upgraded, snooped and evicted; the rest are noise.
  function automatic logic [ADDR_W-1:0] pick_address(int unsigned o, int unsigned ix);
    logic [ADDR_W-1:0] a;
    if ($urandom_range(0, 9) < 2) begin
      return $urandom;
    end
    a = pool_tags[$urandom_range(0, 3)] << (o + ix);
    a = a | ((pool_sets[$urandom_range(0, 3)] & ((32'd1 << ix) - 32'd1)) << o);
    a = a | ($urandom & ((32'd1 << o) - 32'd1));
    return a;
  endfunction

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [1:0] m, input logic [3:0] o_cfg,
                            input logic [2:0] i_cfg, input logic [2:0] w_cfg);
    write_reg(REG_PROTOCOL, PDATA_W'(m));
    write_reg(REG_OFFSET, PDATA_W'(o_cfg));
    write_reg(REG_INDEX, PDATA_W'(i_cfg));
    write_reg(REG_WAYS, PDATA_W'(w_cfg));
    settings_done++;
  endtask

  task automatic send_access(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a);
    int unsigned gap;
    req.valid   <= 1'b1;
    req.func    <= f;
    req.address <= a;
    do @(posedge clk_i); while (!req.ready);
    sb.note_access(f, a);
    @(negedge clk_i);
    gap = req_steady ? 0 : pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [1:0] m, input logic [3:0] o_cfg,
                           input logic [2:0] i_cfg, input logic [2:0] w_cfg,
                           input int unsigned count);
    int unsigned o;
    int unsigned ix;
    set_config(m, o_cfg, i_cfg, w_cfg);
    o          = (32'(o_cfg) > OFFSET_MAX) ? OFFSET_MAX : 32'(o_cfg);
    ix         = (32'(i_cfg) > INDEX_MAX) ? INDEX_MAX : 32'(i_cfg);
    req_steady = ($urandom_range(0, 3) == 0);
    repeat (count) begin
      send_access(pick_func(), pick_address(o, ix));
    end
    drain();
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!long_hold_done && sb.checked >= 300) begin
        long_hold_done = 1'b1;
        stall_left     = 150;
      end
      if (stall_left > 0) begin
        rsp.ready <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        rsp.ready <= 1'b1;
        if ((cycle_count % 400) >= 100) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  always @(posedge clk_i) begin
    rsp_t got;
    if (rst_ni && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      got.hit          = rsp.hit;
      got.writeback    = rsp.writeback;
      got.upgrade_miss = rsp.upgrade_miss;
      got.way          = rsp.way;
      got.new_state    = rsp.new_state;
      sb.check_result(got);
    end
  end

  initial begin
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    req.valid   = 1'b0;
    req.func    = FUNC_LOAD;
    req.address = '0;
    rsp.ready   = 1'b0;
    cycle_count    = 0;
    settings_done  = 0;
    stall_left     = 0;
    long_hold_done = 1'b0;
    req_steady     = 1'b0;
    for (int i = 0; i < 4; i++) begin
      pool_tags[i] = $urandom;
      pool_sets[i] = $urandom;
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_config(MODE_MSI, 4'd4, 3'd2, 3'd2);
    send_access(FUNC_LOAD, 32'h0000_0000);
    send_access(FUNC_STORE, 32'h0000_0000);
    send_access(FUNC_LOAD, 32'h0000_000C);
    send_access(FUNC_SNOOP_LOAD, 32'h0000_0008);
    send_access(FUNC_STORE, 32'h0000_0000);
    send_access(FUNC_SNOOP_STORE, 32'h0000_0000);
    send_access(FUNC_SNOOP_LOAD, 32'h0000_0000);
    send_access(FUNC_SNOOP_STORE, 32'h1234_5670);
    send_access(FUNC_STORE, 32'h0000_0040);
    send_access(FUNC_LOAD, 32'h0000_0080);
    send_access(FUNC_STORE, 32'h0000_00C0);
    send_access(FUNC_STORE, 32'hFFFF_FFFF);
    send_access(FUNC_STORE, 32'hFFFF_FFF0);
    send_access(FUNC_LOAD, 32'hFFFF_FFC0);
    send_access(FUNC_LOAD, 32'hAAAA_AAAA);
    send_access(FUNC_STORE, 32'h5555_5555);
    send_access(FUNC_SNOOP_LOAD, 32'hAAAA_AAAA);
    send_access(FUNC_SNOOP_STORE, 32'h5555_5555);
    send_access(FUNC_LOAD, 32'h8000_0000);
    send_access(FUNC_STORE, 32'h7FFF_FFFF);
    drain();

    run_phase(MODE_PLAIN, 4'd0, 3'd0, 3'd1, 100);
    run_phase(MODE_MSI, 4'd4, 3'd6, 3'd4, 100);
    run_phase(MODE_PLAIN, 4'd4, 3'd6, 3'd4, 100);
    run_phase(MODE_VI, 4'd12, 3'd6, 3'd4, 100);
    run_phase(MODE_MSI_ALIAS, 4'd15, 3'd7, 3'd7, 100);
    run_phase(MODE_MSI, 4'd5, 3'd1, 3'd0, 100);
    run_phase(MODE_VI, 4'd13, 3'd3, 3'd5, 100);
    run_phase(MODE_VI, 4'd2, 3'd1, 3'd3, 100);
    run_phase(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
              3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 100);

    repeat (8) @(negedge clk_i);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
    end
    $display("Checked %0d transactions over %0d register settings, all protocol modes.",
             sb.checked, settings_done);
    $display("Saw %0d hits, %0d writebacks, %0d upgrade misses, %0d snoop misses.",
             sb.hits, sb.writebacks, sb.upgrades, sb.snoop_misses);
    if (sb.errors == 0) begin
      $display("snooping_cache_tag_state_controller: match");
    end else begin
      $display("snooping_cache_tag_state_controller: mismatch");
    end
    $finish;
  end

endmodule
